FILE: src/pfb_pkg.sv
// Shared types, constants and byte tables of the provisioning frame builder.
package pfb_pkg;

  localparam int BUFFER_BYTES   = 128;
  localparam int FRAME_OVERHEAD = 13;
  localparam int URL_MAX        = BUFFER_BYTES - FRAME_OVERHEAD;
  localparam int UL_W           = $clog2(URL_MAX + 1);

  localparam int HDR_BYTES = 7;
  localparam int BODY_MAX  = 5;
  localparam int BODY_W    = $clog2(BODY_MAX + 1);
  localparam int IDX_W     = $clog2(HDR_BYTES + BODY_MAX);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] REQ_STATE = 2'd0;
  localparam logic [1:0] REQ_RPC   = 2'd1;
  localparam logic [1:0] REQ_URL   = 2'd2;

  localparam logic [7:0] VERSION    = 8'h01;
  localparam logic [7:0] TYPE_STATE = 8'h01;
  localparam logic [7:0] TYPE_ERROR = 8'h02;
  localparam logic [7:0] TYPE_RPC   = 8'h04;
  localparam logic [7:0] STATE_LEN  = 8'h01;
  localparam logic [7:0] RPC_LEN_NO_URL = 8'h02;

  localparam logic [7:0] SIG_0 = 8'h49;
  localparam logic [7:0] SIG_1 = 8'h4D;
  localparam logic [7:0] SIG_2 = 8'h50;
  localparam logic [7:0] SIG_3 = 8'h52;
  localparam logic [7:0] SIG_4 = 8'h4F;
  localparam logic [7:0] SIG_5 = 8'h56;

  localparam logic [7:0] HDR_SUM = SIG_0 + SIG_1 + SIG_2 + SIG_3 + SIG_4 + SIG_5 + VERSION;

  typedef struct packed {
    logic                       hdr;
    logic [BODY_W-1:0]          nbytes;
    logic [BODY_MAX-1:0][7:0]   body;
    logic                       last;
  } desc_t;

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      IDX_W'(0): b = SIG_0;
      IDX_W'(1): b = SIG_1;
      IDX_W'(2): b = SIG_2;
      IDX_W'(3): b = SIG_3;
      IDX_W'(4): b = SIG_4;
      IDX_W'(5): b = SIG_5;
      default:   b = VERSION;
    endcase
    return b;
  endfunction

endpackage

FILE: src/provisioning_frame_builder.sv
// Top level of the provisioning reply frame builder.
// Turns requests into serial provisioning frames, one byte per output beat, with
// tlast on the checksum byte that closes a frame. A state request yields 11 beats,
// an RPC start 12 beats with or without a URL, and each URL byte one beat (two
// for the last, which carries the checksum). The output serializer sets the
// sustained rate at one byte per cycle when not stalled; requests are taken in
// every cycle while the four-entry descriptor queue has room, so a burst of URL
// bytes streams at one per cycle and header bursts are paced by the byte output.
module provisioning_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // state_value, command_id, url_length, url_byte
  input  logic [2:0]  in_tuser,   // req_type, error_flag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast
);

  logic           push, full, pop, q_valid;
  pfb_pkg::desc_t push_desc, q_desc;

  pfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .push      (push),
    .push_desc (push_desc)
  );

  pfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  pfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/pfb_front.sv
// Front end: accepts requests, tracks the open URL frame and emits frame descriptors.
module pfb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,
  input  logic [2:0]           in_tuser,
  input  logic                 q_full,
  output logic                 push,
  output pfb_pkg::desc_t       push_desc
);

  logic [7:0]               sum_r, sum_nxt;
  logic [pfb_pkg::UL_W-1:0] left_r, left_nxt;

  logic [1:0]               req;
  logic                     err;
  logic [7:0]               sval, cmd, ulen, ubyte;
  logic [pfb_pkg::UL_W-1:0] len_sat;
  logic [7:0]               len8, url_sum;
  logic                     accept;

  assign req   = in_tuser[1:0];
  assign err   = in_tuser[2];
  assign sval  = in_tdata[7:0];
  assign cmd   = in_tdata[15:8];
  assign ulen  = in_tdata[23:16];
  assign ubyte = in_tdata[31:24];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign len_sat = (ulen > 8'(pfb_pkg::URL_MAX)) ? pfb_pkg::UL_W'(pfb_pkg::URL_MAX)
                                                   : pfb_pkg::UL_W'(ulen);
  assign len8    = 8'(len_sat);
  assign url_sum = sum_r + ubyte;

  always_comb begin
    logic [7:0] tb, ck;
    tb        = err ? pfb_pkg::TYPE_ERROR : pfb_pkg::TYPE_STATE;
    ck        = 8'd0;
    push      = 1'b0;
    push_desc = '0;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    if (accept) begin
      case (req)
        pfb_pkg::REQ_STATE: begin
          ck = pfb_pkg::HDR_SUM + tb + pfb_pkg::STATE_LEN + sval;
          push = 1'b1;
          push_desc.hdr    = 1'b1;
          push_desc.nbytes = pfb_pkg::BODY_W'(4);
          push_desc.body   = {8'd0, ck, sval, pfb_pkg::STATE_LEN, tb};
          push_desc.last   = 1'b1;
          sum_nxt  = 8'd0;
          left_nxt = '0;
        end
        pfb_pkg::REQ_RPC: begin
          push = 1'b1;
          push_desc.hdr    = 1'b1;
          push_desc.nbytes = pfb_pkg::BODY_W'(5);
          if (len_sat != '0) begin
            push_desc.body = {len8, len8 + 8'd1, cmd, len8 + 8'd3, pfb_pkg::TYPE_RPC};
            push_desc.last = 1'b0;
            sum_nxt  = pfb_pkg::HDR_SUM + pfb_pkg::TYPE_RPC + 8'd4 + cmd + len8 + len8 + len8;
            left_nxt = len_sat;
          end else begin
            ck = pfb_pkg::HDR_SUM + pfb_pkg::TYPE_RPC + pfb_pkg::RPC_LEN_NO_URL + cmd;
            push_desc.body = {ck, 8'd0, cmd, pfb_pkg::RPC_LEN_NO_URL, pfb_pkg::TYPE_RPC};
            push_desc.last = 1'b1;
            sum_nxt  = 8'd0;
            left_nxt = '0;
          end
        end
        pfb_pkg::REQ_URL: begin
          if (left_r != '0) begin
            push = 1'b1;
            push_desc.hdr = 1'b0;
            left_nxt = left_r - pfb_pkg::UL_W'(1);
            if (left_r == pfb_pkg::UL_W'(1)) begin
              push_desc.nbytes = pfb_pkg::BODY_W'(2);
              push_desc.body   = {24'd0, url_sum, ubyte};
              push_desc.last   = 1'b1;
              sum_nxt = 8'd0;
            end else begin
              push_desc.nbytes = pfb_pkg::BODY_W'(1);
              push_desc.body   = {32'd0, ubyte};
              push_desc.last   = 1'b0;
              sum_nxt = url_sum;
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= 8'd0;
      left_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

FILE: src/pfb_queue.sv
// Descriptor queue between the front end and the byte serializer.
module pfb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pfb_pkg::desc_t  push_desc,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output pfb_pkg::desc_t  q_desc
);

  pfb_pkg::desc_t            mem_r [pfb_pkg::Q_DEPTH];
  logic [pfb_pkg::Q_AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [pfb_pkg::Q_AW:0]    cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign full    = cnt_r == (pfb_pkg::Q_AW+1)'(pfb_pkg::Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_desc  = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_nxt  = do_push ? wr_r + pfb_pkg::Q_AW'(1) : wr_r;
    rd_nxt  = do_pop  ? rd_r + pfb_pkg::Q_AW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (pfb_pkg::Q_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (pfb_pkg::Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/pfb_back.sv
// Back end: serializes one descriptor into frame bytes through an output register.
module pfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  pfb_pkg::desc_t  q_desc,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  pfb_pkg::desc_t            desc_r, desc_nxt;
  logic                      act_r, act_nxt;
  logic [pfb_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      ov_r, ov_nxt;
  logic [7:0]                od_r, od_nxt;
  logic                      ol_r, ol_nxt;

  logic [pfb_pkg::IDX_W-1:0] total, bidx;
  logic [7:0]                cur;
  logic                      final_b, load;

  assign total   = pfb_pkg::IDX_W'(desc_r.nbytes)
                 + (desc_r.hdr ? pfb_pkg::IDX_W'(pfb_pkg::HDR_BYTES) : '0);
  assign final_b = idx_r == total - pfb_pkg::IDX_W'(1);
  assign bidx    = idx_r - (desc_r.hdr ? pfb_pkg::IDX_W'(pfb_pkg::HDR_BYTES) : '0);
  assign load    = act_r && (!ov_r || out_tready);
  assign pop     = q_valid && (!act_r || (load && final_b));

  always_comb begin
    if (desc_r.hdr && idx_r < pfb_pkg::IDX_W'(pfb_pkg::HDR_BYTES)) begin
      cur = pfb_pkg::hdr_byte(idx_r);
    end else begin
      case (bidx)
        pfb_pkg::IDX_W'(0): cur = desc_r.body[0];
        pfb_pkg::IDX_W'(1): cur = desc_r.body[1];
        pfb_pkg::IDX_W'(2): cur = desc_r.body[2];
        pfb_pkg::IDX_W'(3): cur = desc_r.body[3];
        pfb_pkg::IDX_W'(4): cur = desc_r.body[4];
        default:            cur = 8'd0;
      endcase
    end
  end

  always_comb begin
    desc_nxt = desc_r;
    act_nxt  = act_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt  = 1'b1;
      od_nxt  = cur;
      ol_nxt  = final_b && desc_r.last;
      idx_nxt = idx_r + pfb_pkg::IDX_W'(1);
      if (final_b) begin
        act_nxt = 1'b0;
      end
    end
    if (pop) begin
      desc_nxt = q_desc;
      act_nxt  = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule
